// ===== hdl/cdlt_pkg.sv =====
// cdlt_pkg: constants and types for the cartridge dma length and timing block
// no dependencies; imported by cart_dma_length_and_timing_top
`timescale 1ns / 1ps
`default_nettype none

package cdlt_pkg;

	localparam int CODE_W  = 24;
	localparam int ADDR_W  = 24;
	localparam int LEN_W   = 25;
	localparam int CYC_W   = 33;
	localparam int PAGES_W = 23;
	localparam int COEF_A_W = 9;
	localparam int COEF_B_W = 10;
	localparam int PROD_A_W = COEF_A_W + PAGES_W;
	localparam int PROD_B_W = COEF_B_W + LEN_W - 1;
	localparam int SUM_W    = PROD_B_W;
	localparam int PADDR_W  = 5;

	localparam logic [ADDR_W-1:0] ADDR_MASK   = 24'h7F_FFFE;
	localparam logic [2:0]        OFFSET_MASK = 3'h7;
	localparam logic [COEF_A_W-1:0] FIXED_LATENCY = 9'd14;
	localparam logic [COEF_A_W-1:0] FIXED_EXTRA   = 9'd5;

	// register indexes
	localparam logic [2:0] REG_DOM1_LAT  = 3'd0;
	localparam logic [2:0] REG_DOM1_PWD  = 3'd1;
	localparam logic [2:0] REG_DOM1_PAGE = 3'd2;
	localparam logic [2:0] REG_DOM1_RLS  = 3'd3;
	localparam logic [2:0] REG_DOM2_LAT  = 3'd4;
	localparam logic [2:0] REG_DOM2_PWD  = 3'd5;
	localparam logic [2:0] REG_DOM2_PAGE = 3'd6;
	localparam logic [2:0] REG_DOM2_RLS  = 3'd7;

	typedef struct packed {
		logic [7:0] lat;
		logic [7:0] pwd;
		logic [3:0] page;
		logic [7:0] rls;
	} dom_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/cart_dma_length_and_timing_top.sv =====
// cart_dma_length_and_timing_top: transfer length and cpu cycle count per dma request
// depends on cdlt_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | req_valid, req_stall | length_code, dram_address, second_domain
//  response | rsp_valid, rsp_stall | transfer_length, cpu_cycles
//  config   | apb psel/penable     | paddr, pwdata, prdata
//
// five register stages: input, length/pages, two multipliers, sum, output
// one beat per cycle sustained while rsp_stall is low; each beat passes the stages in order
// each stage moves when the one after it is empty or moving, so bubbles fill
// under a response stall
// arst_n clears stage valids and the domain registers to zero

module cart_dma_length_and_timing_top
	import cdlt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                req_valid,
	output      logic                req_stall,
	input  wire logic [CODE_W-1:0]   length_code,
	input  wire logic [ADDR_W-1:0]   dram_address,
	input  wire logic                second_domain,

	output      logic                rsp_valid,
	input  wire logic                rsp_stall,
	output      logic [LEN_W-1:0]    transfer_length,
	output      logic [CYC_W-1:0]    cpu_cycles,

	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [31:0]         pwdata,
	output      logic [31:0]         prdata,
	output      logic                pready
);

	dom_cfg_t dom1_q, dom2_q;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dom1_q <= '0;
			dom2_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_DOM1_LAT:  dom1_q.lat  <= pwdata[7:0];
				REG_DOM1_PWD:  dom1_q.pwd  <= pwdata[7:0];
				REG_DOM1_PAGE: dom1_q.page <= pwdata[3:0];
				REG_DOM1_RLS:  dom1_q.rls  <= pwdata[7:0];
				REG_DOM2_LAT:  dom2_q.lat  <= pwdata[7:0];
				REG_DOM2_PWD:  dom2_q.pwd  <= pwdata[7:0];
				REG_DOM2_PAGE: dom2_q.page <= pwdata[3:0];
				REG_DOM2_RLS:  dom2_q.rls  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DOM1_LAT:  prdata = {24'd0, dom1_q.lat};
			REG_DOM1_PWD:  prdata = {24'd0, dom1_q.pwd};
			REG_DOM1_PAGE: prdata = {28'd0, dom1_q.page};
			REG_DOM1_RLS:  prdata = {24'd0, dom1_q.rls};
			REG_DOM2_LAT:  prdata = {24'd0, dom2_q.lat};
			REG_DOM2_PWD:  prdata = {24'd0, dom2_q.pwd};
			REG_DOM2_PAGE: prdata = {28'd0, dom2_q.page};
			REG_DOM2_RLS:  prdata = {24'd0, dom2_q.rls};
			default:       prdata = '0;
		endcase
	end

	// stage flow control
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v5_q || !rsp_stall;
	assign en4 = !v4_q || en5;
	assign en3 = !v3_q || en4;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign req_stall = !en1;
	assign rsp_valid = v5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (en1) v1_q <= req_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (en5) v5_q <= v4_q;
		end
	end

	// stage 1: input beat
	logic [CODE_W-1:0] code_s1;
	logic [2:0]        offset_s1;
	logic              dom2_s1;

	always_ff @(posedge clk) begin
		if (en1 && req_valid) begin
			code_s1   <= length_code;
			offset_s1 <= dram_address[2:0] & ADDR_MASK[2:0] & OFFSET_MASK;
			dom2_s1   <= second_domain;
		end
	end

	// stage 2: clamped length, page count, coefficients
	dom_cfg_t              sel_cfg;
	logic [LEN_W-1:0]      len_raw, len_c;
	logic [4:0]            shamt;
	logic [LEN_W:0]        round_up, pages_sum;
	logic [LEN_W-1:0]      len_s2;
	logic [PAGES_W-1:0]    pages_s2;
	logic [COEF_A_W-1:0]   coef_a_s2;
	logic [COEF_B_W-1:0]   coef_b_s2;

	always_comb begin
		sel_cfg   = dom2_s1 ? dom2_q : dom1_q;
		len_raw   = {1'b0, code_s1} + LEN_W'(1);
		len_c     = (len_raw > LEN_W'(offset_s1)) ? (len_raw - LEN_W'(offset_s1)) : '0;
		shamt     = {1'b0, sel_cfg.page} + 5'd2;
		round_up  = ((LEN_W+1)'(1) << shamt) - (LEN_W+1)'(1);
		pages_sum = ({1'b0, len_c} + round_up) >> shamt;
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_q) begin
			len_s2    <= len_c;
			pages_s2  <= pages_sum[PAGES_W-1:0];
			coef_a_s2 <= FIXED_LATENCY + FIXED_EXTRA + COEF_A_W'(sel_cfg.lat) + COEF_A_W'(1);
			coef_b_s2 <= COEF_B_W'(sel_cfg.pwd) + COEF_B_W'(sel_cfg.rls) + COEF_B_W'(2);
		end
	end

	// stage 3: the two products
	logic [LEN_W-1:0]    len_s3;
	logic [PROD_A_W-1:0] prod_a_s3;
	logic [PROD_B_W-1:0] prod_b_s3;

	always_ff @(posedge clk) begin
		if (en3 && v2_q) begin
			len_s3    <= len_s2;
			prod_a_s3 <= PROD_A_W'(coef_a_s2) * PROD_A_W'(pages_s2);
			prod_b_s3 <= PROD_B_W'(coef_b_s2) * PROD_B_W'(len_s2[LEN_W-1:1]);
		end
	end

	// stage 4: cycle sum
	logic [LEN_W-1:0] len_s4;
	logic [SUM_W-1:0] sum_s4;

	always_ff @(posedge clk) begin
		if (en4 && v3_q) begin
			len_s4 <= len_s3;
			sum_s4 <= SUM_W'(prod_a_s3) + prod_b_s3;
		end
	end

	// stage 5: times one and a half, output register
	logic [SUM_W-1:0] cyc_full;
	logic [LEN_W-1:0] len_s5;
	logic [CYC_W-1:0] cyc_s5;

	assign cyc_full = sum_s4 + (sum_s4 >> 1);

	always_ff @(posedge clk) begin
		if (en5 && v4_q) begin
			len_s5 <= len_s4;
			cyc_s5 <= cyc_full[CYC_W-1:0];
		end
	end

	assign transfer_length = len_s5;
	assign cpu_cycles      = cyc_s5;

endmodule

`default_nettype wire
